FILE: rtl/rngb_pkg.sv
package rngb_pkg;

   localparam logic [31:0] RESET_SEED = 32'hBADE4404;
   localparam logic [31:0] OUT_MULT = 32'd36548569;

   localparam logic [3:0] OP_RAW = 4'd0;
   localparam logic [3:0] OP_RANGE = 4'd1;
   localparam logic [3:0] OP_PEEK = 4'd2;
   localparam logic [3:0] OP_READ_SEED = 4'd3;
   localparam logic [3:0] OP_READ_INIT = 4'd4;
   localparam logic [3:0] OP_SET = 4'd5;
   localparam logic [3:0] OP_SET_PAIR = 4'd6;
   localparam logic [3:0] OP_FRAME = 4'd7;
   localparam logic [3:0] OP_CLEAR = 4'd8;

   typedef struct packed {
      logic [3:0] operation;
      logic [5:0] stream_index;
      logic signed [31:0] range_low;
      logic signed [31:0] range_high;
      logic [31:0] seed_value;
      logic [31:0] init_value;
      logic new_frame;
   } req_type;

   typedef struct packed {
      logic [31:0] value;
      logic status;
   } rsp_type;

   typedef enum logic [2:0] {
      VSEL_ZERO,
      VSEL_CUR,
      VSEL_INI,
      VSEL_PROD,
      VSEL_RANGE
   } vsel_type;

   typedef struct packed {
      logic cap;
      logic rd;
      logic ld_seed;
      logic step;
      logic mul;
      logic mod_start;
      logic mod_thr;
      logic thr_ld;
      logic wr_cur;
      logic wr_ini;
      logic clr_step;
      logic rsp_load;
      vsel_type vsel;
      logic status;
   } cmd_type;

   typedef struct packed {
      logic [3:0] op;
      logic idx_ok;
      logic frame_ok;
      logic bound_zero;
      logic below_thr;
      logic mod_busy;
      logic clr_last;
   } stat_type;

   function automatic logic [31:0] step_seed(input logic [31:0] x);
      logic [31:0] t;
      t = x ^ (x >> 13);
      t = t ^ (t >> 11);
      t = t ^ (t << 21);
      return t;
   endfunction

   function automatic logic [31:0] chain_seed(input logic [31:0] x);
      logic [31:0] t;
      t = x ^ (x >> 13);
      t = t ^ (t << 25);
      t = t ^ (t >> 11);
      return t;
   endfunction

endpackage

FILE: rtl/rngb_mod.sv
module rngb_mod import rngb_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [31:0] dividend,
   input logic [31:0] divisor,
   output logic busy,
   output logic [31:0] rem
);

   logic busy_ff;
   logic [4:0] cnt_ff;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dq_ff;
   logic [31:0] dv_ff;
   logic [32:0] trial;

   // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      trial = {rem_ff, dq_ff[31]};
      if (trial >= {1'b0, dv_ff}) begin
         rem_in = 32'(trial - {1'b0, dv_ff});
      end else begin
         rem_in = trial[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dq_ff <= dividend;
         dv_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dq_ff <= {dq_ff[30:0], 1'b0};
      end
   end

   assign busy = busy_ff;
   assign rem = rem_ff;

endmodule

FILE: rtl/rngb_dp.sv
module rngb_dp import rngb_pkg::*; #(
   parameter int NUM_STREAMS = 34,
   parameter int NUM_SYNCED = 32,
   parameter int FRAME_STREAM = 32
) (
   input logic clock,
   input logic reset,
   input req_type req_data,
   output rsp_type rsp_data,
   input logic csr_valid,
   output logic csr_ready,
   input logic [31:0] csr_wdata,
   input cmd_type cmd,
   output stat_type stat
);

   localparam int AW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
   localparam int NCLR = (NUM_SYNCED < NUM_STREAMS) ? NUM_SYNCED : NUM_STREAMS;
   localparam bit FRAME_OK = FRAME_STREAM < NUM_STREAMS;

   req_type req_ff;
   rsp_type rsp_ff;
   logic [31:0] dflt_ff;
   logic [AW-1:0] addr_ff, addr_in, waddr;
   logic [AW+5:0] idx_ext;
   logic [31:0] bound_ff;
   logic [31:0] seed_ff;
   logic [31:0] prod_ff;
   logic [31:0] thr_ff;
   logic [31:0] cs_ff;
   logic [AW-1:0] cnt_ff;
   logic [31:0] cur_mem [NUM_STREAMS];
   logic [31:0] ini_mem [NUM_STREAMS];
   logic [NUM_STREAMS-1:0] cur_vld_ff, ini_vld_ff;
   logic [31:0] cur_q_ff, ini_q_ff;
   logic cur_v_ff, ini_v_ff;
   logic [31:0] cur_d, ini_d, frame_d;
   logic [31:0] cur_wd, ini_wd;
   logic [31:0] nz_sv, nz_iv, nz_cs;
   logic [31:0] mod_dividend, mod_rem;
   logic mod_busy;
   logic [31:0] value_in;

   function automatic logic [31:0] nonzero(input logic [31:0] s, input logic [31:0] d);
      return (s != 32'd0) ? s : d;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dflt_ff <= RESET_SEED;
      end else if (csr_valid) begin
         dflt_ff <= (csr_wdata != 32'd0) ? csr_wdata : RESET_SEED;
      end
   end

   assign idx_ext = {{AW{1'b0}}, req_data.stream_index};
   assign addr_in = (req_data.operation == OP_FRAME) ? AW'(FRAME_STREAM) : idx_ext[AW-1:0];

   assign nz_sv = nonzero(req_ff.seed_value, dflt_ff);
   assign nz_iv = nonzero(req_ff.init_value, dflt_ff);
   assign nz_cs = nonzero(cs_ff, dflt_ff);

   // Entries never written read as the reset seed.
   assign cur_d = cur_v_ff ? cur_q_ff : RESET_SEED;
   assign ini_d = ini_v_ff ? ini_q_ff : RESET_SEED;
   assign frame_d = nonzero(req_ff.new_frame ? cur_d : ini_d, dflt_ff);

   always_comb begin
      case (req_ff.operation)
         OP_RAW, OP_RANGE: begin
            cur_wd = seed_ff;
            ini_wd = ini_d;
         end
         OP_SET: begin
            cur_wd = nz_sv;
            ini_wd = nz_sv;
         end
         OP_SET_PAIR: begin
            cur_wd = nz_sv;
            ini_wd = nz_iv;
         end
         OP_FRAME: begin
            cur_wd = frame_d;
            ini_wd = frame_d;
         end
         default: begin
            cur_wd = nz_cs;
            ini_wd = nz_cs;
         end
      endcase
   end

   assign waddr = (req_ff.operation == OP_CLEAR) ? cnt_ff : addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= '0;
         ini_vld_ff <= '0;
      end else begin
         if (cmd.wr_cur) begin
            cur_vld_ff[waddr] <= 1'b1;
         end
         if (cmd.wr_ini) begin
            ini_vld_ff[waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_cur) begin
         cur_mem[waddr] <= cur_wd;
      end
      if (cmd.wr_ini) begin
         ini_mem[waddr] <= ini_wd;
      end
      if (cmd.rd) begin
         cur_q_ff <= cur_mem[addr_ff];
         ini_q_ff <= ini_mem[addr_ff];
         cur_v_ff <= cur_vld_ff[addr_ff];
         ini_v_ff <= ini_vld_ff[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         req_ff <= req_data;
         addr_ff <= addr_in;
         bound_ff <= 32'(unsigned'(req_data.range_high) - unsigned'(req_data.range_low) + 32'd1);
         cs_ff <= req_data.seed_value;
         cnt_ff <= '0;
      end else if (cmd.clr_step) begin
         cs_ff <= chain_seed(nz_cs);
         cnt_ff <= cnt_ff + AW'(1);
      end
      if (cmd.ld_seed) begin
         seed_ff <= cur_d;
      end else if (cmd.step) begin
         seed_ff <= step_seed(seed_ff);
      end
      if (cmd.mul) begin
         prod_ff <= seed_ff * OUT_MULT;
      end
      if (cmd.thr_ld) begin
         thr_ff <= mod_rem;
      end
   end

   assign mod_dividend = cmd.mod_thr ? (32'd0 - bound_ff) : prod_ff;

   rngb_mod u_mod (
      .clock(clock),
      .reset(reset),
      .start(cmd.mod_start),
      .dividend(mod_dividend),
      .divisor(bound_ff),
      .busy(mod_busy),
      .rem(mod_rem)
   );

   always_comb begin
      case (cmd.vsel)
         VSEL_CUR: value_in = cur_d;
         VSEL_INI: value_in = ini_d;
         VSEL_PROD: value_in = prod_ff;
         VSEL_RANGE: value_in = mod_rem + unsigned'(req_ff.range_low);
         default: value_in = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.value <= value_in;
         rsp_ff.status <= cmd.status;
      end
   end

   assign rsp_data = rsp_ff;

   assign stat.op = req_ff.operation;
   assign stat.idx_ok = {3'b000, req_ff.stream_index} < 9'(NUM_STREAMS);
   assign stat.frame_ok = FRAME_OK;
   assign stat.bound_zero = bound_ff == 32'd0;
   assign stat.below_thr = prod_ff < thr_ff;
   assign stat.mod_busy = mod_busy;
   assign stat.clr_last = cnt_ff == AW'(NCLR - 1);

endmodule

FILE: rtl/rngb_ctrl.sv
module rngb_ctrl import rngb_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input logic rsp_stall,
   input stat_type stat,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEC,
      ST_LOAD,
      ST_TWAIT,
      ST_STEP,
      ST_MUL,
      ST_CHECK,
      ST_RWAIT,
      ST_CLR,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   vsel_type vsel_ff, vsel_in;
   logic stat_ff, stat_in;
   logic rsp_valid_ff;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.vsel = vsel_ff;
      cmd.status = stat_ff;
      state_in = state_ff;
      vsel_in = vsel_ff;
      stat_in = stat_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.cap = 1'b1;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            vsel_in = VSEL_ZERO;
            stat_in = 1'b0;
            if (stat.op > OP_CLEAR || (stat.op <= OP_SET_PAIR && !stat.idx_ok) ||
                (stat.op == OP_FRAME && !stat.frame_ok)) begin
               state_in = ST_FIN;
            end else if (stat.op == OP_CLEAR) begin
               state_in = ST_CLR;
            end else if (stat.op == OP_RANGE && stat.bound_zero) begin
               stat_in = 1'b1;
               state_in = ST_FIN;
            end else begin
               cmd.rd = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.ld_seed = 1'b1;
            case (stat.op)
               OP_READ_SEED: begin
                  vsel_in = VSEL_CUR;
                  state_in = ST_FIN;
               end
               OP_READ_INIT: begin
                  vsel_in = VSEL_INI;
                  state_in = ST_FIN;
               end
               OP_SET, OP_SET_PAIR, OP_FRAME: begin
                  cmd.wr_cur = 1'b1;
                  cmd.wr_ini = 1'b1;
                  state_in = ST_FIN;
               end
               OP_RANGE: begin
                  cmd.mod_start = 1'b1;
                  cmd.mod_thr = 1'b1;
                  state_in = ST_TWAIT;
               end
               default: begin
                  state_in = ST_STEP;
               end
            endcase
         end
         ST_TWAIT: begin
            if (!stat.mod_busy) begin
               cmd.thr_ld = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            vsel_in = VSEL_PROD;
            if (stat.op == OP_RANGE) begin
               // Draws below the threshold are rejected; the stream keeps stepping.
               if (stat.below_thr) begin
                  state_in = ST_STEP;
               end else begin
                  cmd.wr_cur = 1'b1;
                  cmd.mod_start = 1'b1;
                  state_in = ST_RWAIT;
               end
            end else begin
               cmd.wr_cur = stat.op == OP_RAW;
               state_in = ST_FIN;
            end
         end
         ST_RWAIT: begin
            if (!stat.mod_busy) begin
               vsel_in = VSEL_RANGE;
               state_in = ST_FIN;
            end
         end
         ST_CLR: begin
            cmd.wr_cur = 1'b1;
            cmd.wr_ini = 1'b1;
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vsel_ff <= VSEL_ZERO;
         stat_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vsel_ff <= vsel_in;
         stat_ff <= stat_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: rtl/multi_stream_xorshift_rng_bank_top.sv
// Bank of NUM_STREAMS 32-bit xorshift generators, each with a current and an initial seed held
// in two single-port memories, plus a default-seed register written through the csr port.
// One transaction is worked at a time; a finished result sits in the output register while
// the next request is taken. A range draw computes the rejection threshold, tries draws
// until one is not below it (rejections are rare) and takes the final modulo; threshold
// and modulo both use a shared one-bit-per-cycle divider. A clear writes one synced
// stream per cycle, min(NUM_SYNCED, NUM_STREAMS) streams in all. No clearing pass is
// needed after reset.
module multi_stream_xorshift_rng_bank_top import rngb_pkg::*; #(
   parameter int NUM_STREAMS = 34,
   parameter int NUM_SYNCED = 32,
   parameter int FRAME_STREAM = 32
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data,
   input logic csr_valid,
   output logic csr_ready,
   input logic [31:0] csr_wdata
);

   cmd_type cmd;
   stat_type stat;

   rngb_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .stat(stat),
      .cmd(cmd)
   );

   rngb_dp #(
      .NUM_STREAMS(NUM_STREAMS),
      .NUM_SYNCED(NUM_SYNCED),
      .FRAME_STREAM(FRAME_STREAM)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata),
      .cmd(cmd),
      .stat(stat)
   );

endmodule
